// File: hdl/tlvf_pkg.sv
// tlvf_pkg: shared types and constants for the TLV option finder.
// Used by tlvf_parser, tlvf_out_queue and tlv_option_finder; no dependencies.
`default_nettype none

package tlvf_pkg;

    localparam int TLVF_MAX_AREA_BYTES = 65536;

    localparam int TLVF_CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [TLVF_CFG_IDX_W-1:0] CFG_SEARCH_CODE = 2'd0;
    localparam logic [TLVF_CFG_IDX_W-1:0] CFG_MIN_SIZE    = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tlvf_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] start_offset;
        logic [15:0] body_length;
    } tlvf_result_t;

    typedef struct packed {
        logic [15:0] search_code;
        logic [15:0] min_size;
    } tlvf_cfg_t;

endpackage

`default_nettype wire

// File: hdl/tlvf_parser.sv
// tlvf_parser: per-byte option chain walker and match detector.
// Depends on tlvf_pkg (item, result and config types).
`default_nettype none

module tlvf_parser
    import tlvf_pkg::*;
#(
    parameter int MAX_AREA_BYTES = TLVF_MAX_AREA_BYTES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_take,
    input  wire tlvf_item_t   item,
    input  wire tlvf_cfg_t    cfg,
    output logic              res_valid,
    output tlvf_result_t      res
);

    localparam int POS_W = $clog2(MAX_AREA_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_AREA_BYTES);

    logic [1:0]       hdr_cnt_reg,   hdr_cnt_next;
    logic [31:0]      hdr_shift_reg, hdr_shift_next;
    logic [15:0]      body_rem_reg,  body_rem_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [15:0]      opt_start_reg, opt_start_next;
    logic             pending_reg,   pending_next;
    logic             given_reg,     given_next;
    logic             overflow_reg,  overflow_next;

    logic             hit;
    logic [15:0]      hdr_code;
    logic [15:0]      hdr_len;

    assign hdr_code = hdr_shift_reg[23:8];
    assign hdr_len  = {hdr_shift_reg[7:0], item.data_byte};

    always_comb
    begin
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_shift_next = hdr_shift_reg;
        body_rem_next  = body_rem_reg;
        pos_next       = pos_reg;
        opt_start_next = opt_start_reg;
        pending_next   = pending_reg;
        given_next     = given_reg;
        overflow_next  = overflow_reg;
        hit            = 1'b0;
        res_valid      = 1'b0;
        res            = '0;

        if (!given_reg && !overflow_reg)
        begin
            if (pos_reg == POS_MAX)
            begin
                overflow_next = 1'b1;
            end
            else if (body_rem_reg != 16'd0)
            begin
                body_rem_next = body_rem_reg - 16'd1;
                if (body_rem_reg == 16'd1 && pending_reg)
                    hit = 1'b1;
            end
            else
            begin
                if (hdr_cnt_reg == 2'd0)
                    opt_start_next = 16'(pos_reg);
                hdr_shift_next = {hdr_shift_reg[23:0], item.data_byte};
                if (hdr_cnt_reg == 2'd3)
                begin
                    // fourth header byte: code and length complete
                    hdr_cnt_next  = 2'd0;
                    pending_next  = (hdr_code == cfg.search_code) &&
                                    (hdr_len >= cfg.min_size);
                    body_rem_next = hdr_len;
                    if (hdr_len == 16'd0 && pending_next)
                        hit = 1'b1;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
        end

        if (pos_reg != POS_MAX)
            pos_next = pos_reg + POS_W'(1);

        if (hit)
        begin
            res_valid        = 1'b1;
            res.found        = 1'b1;
            res.start_offset = opt_start_next;
            res.body_length  = hdr_shift_next[15:0];
            given_next       = 1'b1;
            pending_next     = 1'b0;
        end
        else if (item.last_byte && !given_reg)
        begin
            res_valid = 1'b1;   // not found: all fields zero
        end

        if (item.last_byte)
        begin
            hdr_cnt_next   = '0;
            hdr_shift_next = '0;
            body_rem_next  = '0;
            pos_next       = '0;
            opt_start_next = '0;
            pending_next   = 1'b0;
            given_next     = 1'b0;
            overflow_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            hdr_shift_reg <= '0;
            body_rem_reg  <= '0;
            pos_reg       <= '0;
            opt_start_reg <= '0;
            pending_reg   <= 1'b0;
            given_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else if (item_take)
        begin
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_shift_reg <= hdr_shift_next;
            body_rem_reg  <= body_rem_next;
            pos_reg       <= pos_next;
            opt_start_reg <= opt_start_next;
            pending_reg   <= pending_next;
            given_reg     <= given_next;
            overflow_reg  <= overflow_next;
        end
    end

    // the last byte of an area always restarts the walk
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item.last_byte |=> pos_reg == '0 && !given_reg)
        else $error("area state not cleared after last byte");

    // at most one found result per area
    a_single_found: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && res_valid && res.found |-> !given_reg)
        else $error("second found result in one area");

    // a header is never being collected while a body is still running
    a_hdr_body: assert property (@(posedge clk) disable iff (!rst_n)
        body_rem_reg != 16'd0 |-> hdr_cnt_reg == 2'd0)
        else $error("header bytes counted inside a body");

endmodule

`default_nettype wire

// File: hdl/tlvf_out_queue.sv
// tlvf_out_queue: two-entry result queue decoupling the parser from the
// downstream stall. Depends on tlvf_pkg (result type).
`default_nettype none

module tlvf_out_queue
    import tlvf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tlvf_result_t  push_data,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tlvf_result_t       out_item
);

    tlvf_result_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("result pushed into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: hdl/tlv_option_finder.sv
// tlv_option_finder: top level of the streaming TLV option search.
// Depends on tlvf_pkg, tlvf_parser and tlvf_out_queue.
`default_nettype none

// The block takes an option area one byte per transaction on the input
// channel, with last_byte set on the final byte. Options are a 16-bit
// big-endian code, a 16-bit length and a body. The first option whose code
// equals search_code and whose length is at least min_size is reported as
// found, with its header offset and length, on the transaction that
// completes its body (a zero-length match on its fourth header byte).
// Otherwise the area's last byte reports not found with zero fields.
// Exactly one result per area. Each byte is handled by the parser, whose
// state registers update on acceptance, so one byte per clock is taken
// while in_stall is low; a result is written into the output queue by
// the byte that caused it. Results go through a two-entry queue, so input
// keeps flowing while one result waits; in_stall rises only when both
// entries hold results. Bytes at offset MAX_AREA_BYTES or beyond stop the
// search. Configuration writes (cfg_ready is always high) should be made
// between areas; the header compare uses the values current at the fourth
// header byte.

module tlv_option_finder
    import tlvf_pkg::*;
#(
    parameter int MAX_AREA_BYTES = TLVF_MAX_AREA_BYTES
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input byte channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire tlvf_item_t                in_item,
    // result channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output tlvf_result_t                   out_item,
    // configuration write channel
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [TLVF_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]               cfg_data
);

    tlvf_cfg_t    cfg_reg;
    logic         item_take;
    logic         res_valid;
    tlvf_result_t res;
    logic         queue_full;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEARCH_CODE: cfg_reg.search_code <= cfg_data;
                CFG_MIN_SIZE:    cfg_reg.min_size    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Stall only when no room is left for a possible result.
    assign in_stall  = queue_full;
    assign item_take = in_valid && !in_stall;

    tlvf_parser #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_take (item_take),
        .item      (in_item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tlvf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_take && res_valid),
        .push_data (res),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
